/* design/utf8_stream_decoder_line_tracker_defines.svh */
// Assertion macros used by the port checker of the UTF-8 decoder.
`ifndef UTF8_STREAM_DECODER_LINE_TRACKER_DEFINES_SVH
`define UTF8_STREAM_DECODER_LINE_TRACKER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define U8D_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define U8D_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/u8d_pkg.sv */
// Shared types and constants of the UTF-8 stream decoder with line tracking.
`default_nettype none
package u8d_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned CP_W          = 21;
    localparam int unsigned IDX_W         = 32;
    localparam int unsigned COUNT_W_DEF   = 32;
    localparam int unsigned M_TDATA_W     = 120;

    localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_MAX         = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI     = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_LF          = 21'h00000A;
    localparam logic [CP_W-1:0] CP_CR          = 21'h00000D;
    localparam logic [CP_W-1:0] CP_MIN_2       = 21'h000080;
    localparam logic [CP_W-1:0] CP_MIN_3       = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN_4       = 21'h010000;

    localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'h1F;
    localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'h0F;
    localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'h07;

    localparam logic [2:0] SEQ_LEN_2 = 3'd2;
    localparam logic [2:0] SEQ_LEN_3 = 3'd3;
    localparam logic [2:0] SEQ_LEN_4 = 3'd4;

    // What the byte decoder hands to the line tracker for one input byte.
    typedef struct packed {
        logic            step;     // an input byte is processed this cycle
        logic            restart;  // state is cleared before the byte
        logic            eos;      // byte is the last of the stream
        logic            have;     // a valid code point completed
        logic            bad;      // an encoding error is reported
        logic [CP_W-1:0] cp;       // code point or replacement
    } t_event;

endpackage
`default_nettype wire

/* design/utf8_stream_decoder_line_tracker.sv */
// UTF-8 stream decoder with code point indexing and line tracking.
//
// Slave channel: one raw byte per transaction in tdata, tlast marks the last
// byte of a stream, tuser set clears all state before its byte is decoded.
// Master channel: one transaction per completed code point or reported
// encoding error. tuser flags an error, whose code point is U+FFFD; after an
// error all bytes are dropped until a byte arrives with tuser set.
// Lead bytes and inner continuation bytes give no transaction unless in error.
//
// A byte accepted from the slave side lands in the input register, and the
// decode and counter update logic then loads its result into the output
// register, from which the master side shows it. One byte is taken every
// cycle while the receiver takes results; the only loop is the update of the
// sequence and counter state.
// Index, line and line start counters are COUNT_WIDTH bits and saturate;
// the master side shows their low 32 bits.
//
// Reset clears the valid flags of both pipeline registers and all decoder
// state. When the receiver stalls, the result holds, one more byte waits in
// the input register, then o_s_axis_tready drops until the result is taken.
`default_nettype none
module utf8_stream_decoder_line_tracker #(
    parameter int unsigned COUNT_WIDTH = u8d_pkg::COUNT_W_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [7:0] in_byte
    input  wire logic [u8d_pkg::BYTE_W-1:0]    i_s_axis_tdata,
    input  wire logic                          i_s_axis_tlast,
    // [0] restart
    input  wire logic                          i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // [20:0] code_point, [52:21] point_index, [84:53] line_number,
    // [116:85] line_start_index, [119:117] zero
    output logic [u8d_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,
    // [0] bad_encoding
    output logic                               o_m_axis_tuser
);
    import u8d_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_eos;
    logic              r_in_restart;

    logic              r_out_valid;
    logic [CP_W-1:0]   r_out_cp;
    logic              r_out_bad;
    logic [IDX_W-1:0]  r_out_index;
    logic [IDX_W-1:0]  r_out_line;
    logic [IDX_W-1:0]  r_out_start;

    logic              advance;
    logic              step;
    t_event            ev;
    logic [IDX_W-1:0]  point_index;
    logic [IDX_W-1:0]  line_number;
    logic [IDX_W-1:0]  line_start;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;

    u8d_byte_decoder u_decoder (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_byte    (r_in_byte),
        .i_eos     (r_in_eos),
        .i_restart (r_in_restart),
        .o_event   (ev)
    );

    u8d_line_tracker #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lines (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_event       (ev),
        .o_point_index (point_index),
        .o_line_number (line_number),
        .o_line_start  (line_start)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte    <= i_s_axis_tdata;
            r_in_eos     <= i_s_axis_tlast;
            r_in_restart <= i_s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && (ev.have || ev.bad);
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && (ev.have || ev.bad)) begin
            r_out_cp    <= ev.cp;
            r_out_bad   <= ev.bad;
            r_out_index <= point_index;
            r_out_line  <= line_number;
            r_out_start <= line_start;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_bad;
    assign o_m_axis_tdata  = M_TDATA_W'({r_out_start, r_out_line, r_out_index, r_out_cp});

endmodule
`default_nettype wire

/* design/u8d_byte_decoder.sv */
// Byte-level UTF-8 sequence assembly and validation with its sequence state.
`default_nettype none
module u8d_byte_decoder (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic [u8d_pkg::BYTE_W-1:0] i_byte,
    input  wire logic                       i_eos,
    input  wire logic                       i_restart,
    output u8d_pkg::t_event                 o_event
);
    import u8d_pkg::*;

    logic [1:0]      r_bytes_needed, n_bytes_needed;
    logic [2:0]      r_seq_length,   n_seq_length;
    logic [CP_W-1:0] r_partial,      n_partial;
    logic            r_dead,         n_dead;

    logic [1:0]      cur_needed;
    logic [2:0]      cur_len;
    logic [CP_W-1:0] cur_partial;
    logic            cur_dead;
    logic [CP_W-1:0] shifted;
    logic [CP_W-1:0] min_value;
    logic            have;
    logic            bad;
    logic [CP_W-1:0] cp;

    always_comb begin
        cur_needed  = i_restart ? 2'd0 : r_bytes_needed;
        cur_len     = i_restart ? 3'd0 : r_seq_length;
        cur_partial = i_restart ? '0 : r_partial;
        cur_dead    = i_restart ? 1'b0 : r_dead;

        n_bytes_needed = cur_needed;
        n_seq_length   = cur_len;
        n_partial      = cur_partial;
        n_dead         = cur_dead;
        have           = 1'b0;
        bad            = 1'b0;
        cp             = '0;
        shifted        = {cur_partial[CP_W-7:0], i_byte[5:0]};

        case (cur_len)
            SEQ_LEN_2: min_value = CP_MIN_2;
            SEQ_LEN_3: min_value = CP_MIN_3;
            default:   min_value = CP_MIN_4;
        endcase

        if (!cur_dead) begin
            if (cur_needed == 2'd0) begin
                if (i_byte inside {[8'h00:8'h7F]}) begin
                    cp   = CP_W'(i_byte);
                    have = 1'b1;
                end else if (i_byte inside {[8'hC0:8'hDF]}) begin
                    n_bytes_needed = 2'd1;
                    n_seq_length   = SEQ_LEN_2;
                    n_partial      = CP_W'(i_byte & MASK_LEAD2);
                end else if (i_byte inside {[8'hE0:8'hEF]}) begin
                    n_bytes_needed = 2'd2;
                    n_seq_length   = SEQ_LEN_3;
                    n_partial      = CP_W'(i_byte & MASK_LEAD3);
                end else if (i_byte inside {[8'hF0:8'hF7]}) begin
                    n_bytes_needed = 2'd3;
                    n_seq_length   = SEQ_LEN_4;
                    n_partial      = CP_W'(i_byte & MASK_LEAD4);
                end else begin
                    bad = 1'b1;
                end
            end else if (i_byte[7:6] != 2'b10) begin
                bad = 1'b1;
            end else begin
                n_bytes_needed = cur_needed - 2'd1;
                n_partial      = shifted;
                if (n_bytes_needed == 2'd0) begin
                    // The last byte decides overlong, surrogate and range errors.
                    if (shifted < min_value || shifted > CP_MAX ||
                        (shifted >= CP_SURR_LO && shifted <= CP_SURR_HI)) begin
                        bad = 1'b1;
                    end else begin
                        cp   = shifted;
                        have = 1'b1;
                    end
                    n_seq_length = 3'd0;
                    n_partial    = '0;
                end
            end

            // A sequence left open by the last byte of the stream is cut short.
            if (!bad && !have && i_eos && n_bytes_needed != 2'd0) begin
                bad = 1'b1;
            end

            if (bad) begin
                cp             = CP_REPLACEMENT;
                have           = 1'b0;
                n_bytes_needed = 2'd0;
                n_seq_length   = 3'd0;
                n_partial      = '0;
                n_dead         = 1'b1;
            end
        end

        o_event.step    = i_step;
        o_event.restart = i_restart;
        o_event.eos     = i_eos;
        o_event.have    = have;
        o_event.bad     = bad;
        o_event.cp      = cp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_needed <= 2'd0;
            r_seq_length   <= 3'd0;
            r_partial      <= '0;
            r_dead         <= 1'b0;
        end else if (i_step) begin
            r_bytes_needed <= n_bytes_needed;
            r_seq_length   <= n_seq_length;
            r_partial      <= n_partial;
            r_dead         <= n_dead;
        end
    end

endmodule
`default_nettype wire

/* design/u8d_line_tracker.sv */
// Saturating code point and line counters with CR/LF line-end resolution.
`default_nettype none
module u8d_line_tracker #(
    parameter int unsigned COUNT_WIDTH = u8d_pkg::COUNT_W_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire u8d_pkg::t_event           i_event,
    output logic [u8d_pkg::IDX_W-1:0]      o_point_index,
    output logic [u8d_pkg::IDX_W-1:0]      o_line_number,
    output logic [u8d_pkg::IDX_W-1:0]      o_line_start
);
    import u8d_pkg::*;

    logic [COUNT_WIDTH-1:0] r_points, n_points;
    logic [COUNT_WIDTH-1:0] r_lines,  n_lines;
    logic [COUNT_WIDTH-1:0] r_begin,  n_begin;
    logic                   r_cr,     n_cr;

    logic [COUNT_WIDTH-1:0] cur_points, cur_lines, cur_begin;
    logic                   cur_cr;
    logic [COUNT_WIDTH-1:0] rep_lines, rep_begin;
    logic                   is_lf, is_cr;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] x);
        return (x == '1) ? x : x + COUNT_WIDTH'(1);
    endfunction

    function automatic logic [IDX_W-1:0] low_word(input logic [COUNT_WIDTH-1:0] x);
        logic [63:0] wide;
        wide = 64'(x);
        return wide[IDX_W-1:0];
    endfunction

    always_comb begin
        cur_points = i_event.restart ? '0 : r_points;
        cur_lines  = i_event.restart ? '0 : r_lines;
        cur_begin  = i_event.restart ? '0 : r_begin;
        cur_cr     = i_event.restart ? 1'b0 : r_cr;

        is_lf = i_event.have && (i_event.cp == CP_LF);
        is_cr = i_event.have && (i_event.cp == CP_CR);

        // A pending CR ends its line before any result but an LF is shown.
        if (cur_cr && !is_lf) begin
            rep_lines = sat_inc(cur_lines);
            rep_begin = cur_points;
        end else begin
            rep_lines = cur_lines;
            rep_begin = cur_begin;
        end

        n_points = cur_points;
        n_lines  = cur_lines;
        n_begin  = cur_begin;
        n_cr     = cur_cr;

        if (i_event.have || i_event.bad) begin
            n_lines = rep_lines;
            n_begin = rep_begin;
            n_cr    = 1'b0;
            if (i_event.have) begin
                n_points = sat_inc(cur_points);
                if (is_lf) begin
                    n_lines = sat_inc(rep_lines);
                    n_begin = n_points;
                end else if (is_cr) begin
                    n_cr = 1'b1;
                end
            end
            // A CR on the last byte of the stream ends its line at once.
            if (i_event.eos && n_cr) begin
                n_lines = sat_inc(n_lines);
                n_begin = n_points;
                n_cr    = 1'b0;
            end
        end

        o_point_index = low_word(cur_points);
        o_line_number = low_word(rep_lines);
        o_line_start  = low_word(rep_begin);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= '0;
            r_lines  <= '0;
            r_begin  <= '0;
            r_cr     <= 1'b0;
        end else if (i_event.step) begin
            r_points <= n_points;
            r_lines  <= n_lines;
            r_begin  <= n_begin;
            r_cr     <= n_cr;
        end
    end

endmodule
`default_nettype wire

/* design/u8d_port_checker.sv */
// Port-level assertions for the UTF-8 decoder and their bind to the top level.
`default_nettype none
`include "utf8_stream_decoder_line_tracker_defines.svh"
module u8d_port_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_s_axis_tready,
    input wire logic                          o_m_axis_tvalid,
    input wire logic                          i_m_axis_tready,
    input wire logic [u8d_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic                          o_m_axis_tuser
);
    import u8d_pkg::*;

    logic [CP_W-1:0] out_cp;
    logic            out_good;
    logic            in_range;

    assign out_cp   = o_m_axis_tdata[CP_W-1:0];
    assign out_good = o_m_axis_tvalid && !o_m_axis_tuser;
    assign in_range = (out_cp <= CP_MAX) && !((out_cp >= CP_SURR_LO) && (out_cp <= CP_SURR_HI));

    // An error result always carries the replacement character.
    `U8D_ASSERT_SAME(a_err_is_replacement, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser, out_cp == CP_REPLACEMENT, "error result without U+FFFD")

    // A good result is a scalar value: in range and not a surrogate.
    `U8D_ASSERT_SAME(a_good_is_scalar, i_clk, i_rst_n, out_good, in_range, "decoded value is not a Unicode scalar value")

    // With the output register empty, a byte can always be taken.
    `U8D_ASSERT_SAME(a_empty_takes_input, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready, "input blocked while no result is pending")

    // A stalled result stays put.
    `U8D_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "stalled result changed")

endmodule

bind utf8_stream_decoder_line_tracker u8d_port_checker u_port_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
`default_nettype wire

/* tb/tb_utf8_stream_decoder_line_tracker.sv */
// Self-checking testbench of the UTF-8 stream decoder with line tracking.
`timescale 1ns / 100ps

module tb_utf8_stream_decoder_line_tracker;
    import u8d_pkg::*;

    localparam int unsigned LONG_HOLD_CYCLES = 150;
    localparam int unsigned WATCHDOG_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES     = 20;

    // One raw byte of the stream with its side flags.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              eos;
        logic              restart;
    } t_raw_byte;

    // One decoded code point as the master side reports it.
    typedef struct packed {
        logic [CP_W-1:0]  cp;
        logic             bad;
        logic [IDX_W-1:0] index;
        logic [IDX_W-1:0] line;
        logic [IDX_W-1:0] line_start;
    } t_decoded;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    logic [BYTE_W-1:0]       i_s_axis_tdata = '0;
    logic                    i_s_axis_tlast = 1'b0;
    logic                    i_s_axis_tuser = 1'b0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]    o_m_axis_tdata;
    logic                    o_m_axis_tuser;

    t_raw_byte byte_queue[$];
    t_decoded  decoded_expect[$];
    t_raw_byte drive_item;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_token = 0;
    int mismatch_count = 0;
    int gen_count = 0;
    bit gen_restart = 1'b0;

    // Shadow decoder state.
    logic [1:0]       dec_need;
    logic [2:0]       dec_len;
    logic [CP_W-1:0]  dec_partial;
    logic             dec_dead;
    logic             dec_cr;
    logic [IDX_W-1:0] point_count;
    logic [IDX_W-1:0] line_count;
    logic [IDX_W-1:0] line_begin;

    utf8_stream_decoder_line_tracker i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [IDX_W-1:0] sat_inc(input logic [IDX_W-1:0] x);
        return (x == '1) ? x : x + 1'b1;
    endfunction

    task automatic clear_decoder();
        dec_need    = '0;
        dec_len     = '0;
        dec_partial = '0;
        dec_dead    = 1'b0;
        dec_cr      = 1'b0;
        point_count = '0;
        line_count  = '0;
        line_begin  = '0;
    endtask

    task automatic end_line();
        line_count = sat_inc(line_count);
        line_begin = point_count;
    endtask

    // Advances the shadow decoder by one byte and queues the result it causes.
    task automatic decode_byte(input t_raw_byte it);
        logic [BYTE_W-1:0] b;
        logic              have;
        logic              bad;
        logic [CP_W-1:0]   cp;
        logic [CP_W-1:0]   lo;
        t_decoded          res;
        b    = it.data;
        have = 1'b0;
        bad  = 1'b0;
        cp   = '0;
        if (it.restart)
            clear_decoder();
        if (dec_dead)
            return;
        if (dec_need == 0) begin
            if (!b[7]) begin
                cp   = CP_W'(b);
                have = 1'b1;
            end else if (b[7:5] == 3'b110) begin
                dec_need    = 2'd1;
                dec_len     = SEQ_LEN_2;
                dec_partial = CP_W'(b & MASK_LEAD2);
            end else if (b[7:4] == 4'b1110) begin
                dec_need    = 2'd2;
                dec_len     = SEQ_LEN_3;
                dec_partial = CP_W'(b & MASK_LEAD3);
            end else if (b[7:3] == 5'b11110) begin
                dec_need    = 2'd3;
                dec_len     = SEQ_LEN_4;
                dec_partial = CP_W'(b & MASK_LEAD4);
            end else begin
                bad = 1'b1;
            end
        end else if (b[7:6] != 2'b10) begin
            bad = 1'b1;
        end else begin
            dec_partial = {dec_partial[CP_W-7:0], b[5:0]};
            dec_need    = dec_need - 1'b1;
            if (dec_need == 0) begin
                case (dec_len)
                    SEQ_LEN_2: lo = CP_MIN_2;
                    SEQ_LEN_3: lo = CP_MIN_3;
                    default:   lo = CP_MIN_4;
                endcase
                if (dec_partial < lo || dec_partial > CP_MAX ||
                    (dec_partial >= CP_SURR_LO && dec_partial <= CP_SURR_HI)) begin
                    bad = 1'b1;
                end else begin
                    cp   = dec_partial;
                    have = 1'b1;
                end
                dec_len     = '0;
                dec_partial = '0;
            end
        end

        // A sequence left open by the last byte of the stream is cut short.
        if (!bad && !have && it.eos && dec_need != 0)
            bad = 1'b1;
        if (!bad && !have)
            return;
        if (bad) begin
            cp   = CP_REPLACEMENT;
            have = 1'b0;
        end

        if (dec_cr && !(have && cp == CP_LF))
            end_line();
        dec_cr = 1'b0;

        res.cp         = cp;
        res.bad        = bad;
        res.index      = point_count;
        res.line       = line_count;
        res.line_start = line_begin;
        decoded_expect.push_back(res);

        if (have) begin
            point_count = sat_inc(point_count);
            if (cp == CP_LF)
                end_line();
            else if (cp == CP_CR)
                dec_cr = 1'b1;
        end else begin
            dec_dead    = 1'b1;
            dec_need    = '0;
            dec_len     = '0;
            dec_partial = '0;
        end

        if (it.eos && dec_cr) begin
            end_line();
            dec_cr = 1'b0;
        end
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] data, input bit eos, input bit counted);
        t_raw_byte it;
        it.data     = data;
        it.eos      = eos;
        it.restart  = gen_restart;
        gen_restart = 1'b0;
        byte_queue.push_back(it);
        if (counted)
            gen_count++;
    endtask

    // Pushes the lead byte and the first ncont continuation bytes of a len-byte
    // encoding of cp; eos goes on the last byte pushed.
    task automatic push_seq(input logic [CP_W-1:0] cp, input int len, input int ncont,
                            input bit eos);
        logic [BYTE_W-1:0] lead;
        int                shift;
        case (len)
            1:       lead = {1'b0, cp[6:0]};
            2:       lead = {3'b110, cp[10:6]};
            3:       lead = {4'b1110, cp[15:12]};
            default: lead = {5'b11110, cp[20:18]};
        endcase
        push_byte(lead, eos && ncont == 0, 1'b1);
        for (int i = 1; i <= ncont; i++) begin
            shift = 6 * (len - 1 - i);
            push_byte({2'b10, cp[shift +: 6]}, eos && i == ncont, 1'b1);
        end
    endtask

    // After an error a few ignored bytes may follow before the restart.
    task automatic revive_after_error();
        int n;
        n = $urandom_range(2, 0);
        for (int i = 0; i < n; i++)
            push_byte(BYTE_W'($urandom), 1'($urandom_range(1)), 1'b0);
        gen_restart = 1'b1;
    endtask

    task automatic push_random(input int budget);
        int              sel;
        int              len;
        int              ncont;
        int              r;
        logic [CP_W-1:0] cp;
        logic [BYTE_W-1:0] b;
        gen_count = 0;
        while (gen_count < budget) begin
            sel = $urandom_range(99);
            if ($urandom_range(99) == 0)
                gen_restart = 1'b1;
            if (sel < 55) begin
                r  = $urandom_range(9);
                cp = (r < 2) ? CP_LF : (r < 4) ? CP_CR : CP_W'($urandom_range(127));
                push_seq(cp, 1, 0, $urandom_range(29) == 0);
            end else if (sel < 67) begin
                push_seq(CP_W'($urandom_range(32'h7FF, 32'h80)), 2, 1, $urandom_range(29) == 0);
            end else if (sel < 79) begin
                cp = CP_W'($urandom_range(32'hFFFF, 32'h800));
                if (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
                    cp = cp ^ 21'h002000;
                push_seq(cp, 3, 2, $urandom_range(29) == 0);
            end else if (sel < 89) begin
                push_seq(CP_W'($urandom_range(32'h10FFFF, 32'h10000)), 4, 3,
                         $urandom_range(29) == 0);
            end else if (sel < 91) begin
                // Overlong form, C0 and C1 leads among them.
                len = $urandom_range(4, 2);
                cp  = CP_W'($urandom_range((len == 2) ? 32'h7F : (len == 3) ? 32'h7FF : 32'hFFFF));
                push_seq(cp, len, len - 1, 1'b0);
                revive_after_error();
            end else if (sel < 92) begin
                push_seq(CP_W'($urandom_range(32'hDFFF, 32'hD800)), 3, 2, 1'b0);
                revive_after_error();
            end else if (sel < 93) begin
                push_seq(CP_W'($urandom_range(32'h1FFFFF, 32'h110000)), 4, 3, 1'b0);
                revive_after_error();
            end else if (sel < 94) begin
                len   = $urandom_range(4, 2);
                ncont = $urandom_range(len - 2, 0);
                push_seq(CP_W'($urandom), len, ncont, 1'b0);
                b = BYTE_W'($urandom);
                if (b[7:6] == 2'b10)
                    b[7] = 1'b0;
                push_byte(b, 1'($urandom_range(1)), 1'b1);
                revive_after_error();
            end else if (sel < 95) begin
                len   = $urandom_range(4, 2);
                ncont = $urandom_range(len - 2, 0);
                push_seq(CP_W'($urandom), len, ncont, 1'b1);
                revive_after_error();
            end else if (sel < 96) begin
                if ($urandom_range(1))
                    push_byte(BYTE_W'($urandom_range(8'hBF, 8'h80)), 1'($urandom_range(1)),
                              1'b1);
                else
                    push_byte(BYTE_W'($urandom_range(8'hFF, 8'hF8)), 1'($urandom_range(1)),
                              1'b1);
                revive_after_error();
            end else if (sel < 98) begin
                r = $urandom_range(6, 1);
                for (int i = 0; i < r; i++)
                    push_byte(BYTE_W'($urandom), $urandom_range(7) == 0, 1'b1);
                gen_restart = 1'b1;
            end else begin
                // Sequence abandoned part way by a restart.
                len   = $urandom_range(4, 2);
                ncont = $urandom_range(len - 2, 0);
                push_seq(CP_W'($urandom), len, ncont, 1'b0);
                gen_restart = 1'b1;
            end
        end
    endtask

    task automatic push_directed();
        gen_restart = 1'b1;
        push_seq(21'h000000, 1, 0, 1'b0);
        push_seq(21'h00007F, 1, 0, 1'b0);
        push_seq(CP_MIN_2, 2, 1, 1'b0);
        push_seq(21'h0007FF, 2, 1, 1'b0);
        push_seq(CP_MIN_3, 3, 2, 1'b0);
        push_seq(CP_MIN_4, 4, 3, 1'b0);
        push_seq(CP_MAX, 4, 3, 1'b0);
        push_seq(CP_CR, 1, 0, 1'b0);
        push_seq(CP_LF, 1, 0, 1'b0);
        // A CR on the last byte of the stream closes its line at once.
        push_seq(CP_CR, 1, 0, 1'b1);
        // The stream goes on after its end; the CR is then closed by an error.
        push_seq(CP_CR, 1, 0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b1);
        push_byte(8'h41, 1'b0, 1'b1);
        gen_restart = 1'b1;
        push_seq(21'h000000, 2, 1, 1'b0);
        gen_restart = 1'b1;
        push_seq(CP_SURR_LO, 3, 2, 1'b0);
        gen_restart = 1'b1;
        push_seq(21'h110000, 4, 3, 1'b0);
        gen_restart = 1'b1;
        push_seq(21'h002000, 3, 0, 1'b1);
        gen_restart = 1'b1;
        push_seq(21'h002000, 3, 0, 1'b0);
        push_byte(8'h41, 1'b0, 1'b1);
        gen_restart = 1'b1;
        push_byte(8'h80, 1'b0, 1'b1);
        gen_restart = 1'b1;
        push_seq(21'h000041, 1, 0, 1'b0);
    endtask

    task automatic wait_drained();
        while (byte_queue.size() != 0 || i_s_axis_tvalid)
            @(negedge i_clk);
        while (decoded_expect.size() != 0)
            @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                decode_byte(drive_item);
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drive_item      = byte_queue.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= drive_item.data;
                    i_s_axis_tlast  <= drive_item.eos;
                    i_s_axis_tuser  <= drive_item.restart;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    int hold_left;
    int seen_token;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            hold_left       <= 0;
            seen_token      <= 0;
        end else if (stall_token != seen_token) begin
            seen_token      <= stall_token;
            hold_left       <= LONG_HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_decoded want;
        t_decoded got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.cp         = o_m_axis_tdata[20:0];
            got.index      = o_m_axis_tdata[52:21];
            got.line       = o_m_axis_tdata[84:53];
            got.line_start = o_m_axis_tdata[116:85];
            got.bad        = o_m_axis_tuser;
            if (decoded_expect.size() == 0) begin
                $error("unexpected result transaction: code_point %h", got.cp);
                mismatch_count++;
            end else begin
                want = decoded_expect.pop_front();
                if (got.cp !== want.cp) begin
                    $error("code_point: expected %h, got %h", want.cp, got.cp);
                    mismatch_count++;
                end
                if (got.bad !== want.bad) begin
                    $error("bad_encoding: expected %b, got %b", want.bad, got.bad);
                    mismatch_count++;
                end
                if (got.index !== want.index) begin
                    $error("point_index: expected %0d, got %0d", want.index, got.index);
                    mismatch_count++;
                end
                if (got.line !== want.line) begin
                    $error("line_number: expected %0d, got %0d", want.line, got.line);
                    mismatch_count++;
                end
                if (got.line_start !== want.line_start) begin
                    $error("line_start_index: expected %0d, got %0d",
                           want.line_start, got.line_start);
                    mismatch_count++;
                end
            end
        end
    end

    int idle_cycles;

    // Ends the run when no transaction moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        clear_decoder();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 20;
        recv_idle_pct = 48;
        push_directed();
        wait_drained();

        push_random(240);
        // The receiver is held off for a long stall, so the input side backs up.
        stall_token++;
        wait_drained();

        send_idle_pct = 48;
        recv_idle_pct = 20;
        push_random(230);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random(230);
        stall_token++;
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
